[hw/rtl/bwar_pkg.sv]
// ----------------------------------------------------------------------------
// bwar_pkg: shared types and constants for black/white alpha recovery
// Byte and quotient widths, channel count and alpha position.
// ----------------------------------------------------------------------------
package bwar_pkg;

    localparam int BYTE_W    = 8;
    localparam int PIX_W     = 32;
    localparam int QUOT_W    = 16;
    localparam int ALPHA_LSB = 24;
    localparam int NUM_CHAN  = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [QUOT_W-1:0] t_quot;
    typedef logic [PIX_W-1:0]  t_pixel;

    // request to the shared divider
    typedef struct packed {
        logic  start;
        t_byte channel;
        t_byte divisor;
    } t_div_req;

    // answer from the shared divider
    typedef struct packed {
        logic  done;
        t_quot quot;
    } t_div_rsp;

endpackage

[hw/rtl/bwar_if.sv]
// ----------------------------------------------------------------------------
// bwar_if: item channels of the alpha recovery block
// Input channel carries a pixel pair, output channel a result item.
// ----------------------------------------------------------------------------
interface bwar_in_if
    import bwar_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel black_pixel;
    t_byte  white_green;
    logic   frame_last;

    modport source (output valid, black_pixel, white_green, frame_last, input ready);
    modport sink   (input valid, black_pixel, white_green, frame_last, output ready);
endinterface

interface bwar_out_if
    import bwar_pkg::*;
;
    logic   valid;
    logic   ready;
    t_pixel out_pixel;
    logic   is_last;
    logic   alpha_uniform;
    logic   color_uniform;
    t_byte  first_alpha_byte;
    t_quot  unpremul_low;
    t_quot  unpremul_mid;
    t_quot  unpremul_high;

    modport source (output valid, out_pixel, is_last, alpha_uniform, color_uniform,
                    first_alpha_byte, unpremul_low, unpremul_mid, unpremul_high,
                    input ready);
    modport sink   (input valid, out_pixel, is_last, alpha_uniform, color_uniform,
                    first_alpha_byte, unpremul_low, unpremul_mid, unpremul_high,
                    output ready);
endinterface

[hw/rtl/bwar_div.sv]
// ----------------------------------------------------------------------------
// bwar_div: radix-2 restoring divider
// Divides (channel << 8) by an 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwar_div
    import bwar_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_quot             r_num;
    t_byte             r_rem;
    t_byte             r_div;

    logic [BYTE_W:0]   rem_sh;
    logic              fits;
    logic [BYTE_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[QUOT_W-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the low end as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {i_req.channel, {BYTE_W{1'b0}}};
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[QUOT_W-2:0], fits};
            r_rem <= fits ? rem_sub[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

[hw/rtl/black_white_alpha_recovery.sv]
// ----------------------------------------------------------------------------
// black_white_alpha_recovery: alpha from renderings over black and white
// Rebuilds per-pixel alpha and analyzes uniformity over one image.
// ----------------------------------------------------------------------------
// Each item is a pixel rendered over black plus the green byte of the same
// pixel over white; the result is the black pixel with the recovered alpha in
// its top byte. Ordinary pixels, and a last pixel whose color is not uniform
// or whose first alpha is zero, are written straight to the output register,
// and a new item is taken while the previous result waits, as long as the
// output register is freed. A last pixel with uniform color runs the three
// color bytes of the first pixel through one shared bit-serial divider, one
// byte after another, and no item is accepted while the division runs.
// ----------------------------------------------------------------------------
module black_white_alpha_recovery
    import bwar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bwar_in_if.sink     i_in,
    bwar_out_if.source  o_out
);

    typedef enum logic {ST_IDLE, ST_DIV} t_state;

    t_state      r_state;
    logic [1:0]  r_chan;
    logic        r_div_start;
    logic        r_first_seen;
    t_pixel      r_first;
    t_pixel      r_diff;

    logic        r_o_valid;
    t_pixel      r_o_pixel;
    logic        r_o_last;
    logic        r_o_au;
    logic        r_o_cu;
    t_byte       r_o_fa;
    t_quot       r_o_low;
    t_quot       r_o_mid;
    t_quot       r_o_high;

    t_byte       alpha;
    t_pixel      pix;
    t_pixel      first_pix;
    t_pixel      diff;
    logic        au;
    logic        cu;
    t_byte       fa;
    logic        accept;
    logic        out_free;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    always_comb begin
        alpha     = BYTE_W'(8'hFF - i_in.white_green + i_in.black_pixel[15:8]);
        pix       = {alpha, i_in.black_pixel[ALPHA_LSB-1:0]};
        first_pix = r_first_seen ? r_first : pix;
        diff      = r_diff | (first_pix ^ pix);
        au        = (diff[PIX_W-1:ALPHA_LSB] == '0);
        cu        = au && (diff[ALPHA_LSB-1:0] == '0);
        fa        = first_pix[PIX_W-1:ALPHA_LSB];
    end

    assign out_free   = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        div_req.start   = r_div_start;
        div_req.divisor = r_first[PIX_W-1:ALPHA_LSB];
        case (r_chan)
            2'd0:    div_req.channel = r_first[7:0];
            2'd1:    div_req.channel = r_first[15:8];
            default: div_req.channel = r_first[23:16];
        endcase
    end

    bwar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_chan       <= '0;
            r_div_start  <= 1'b0;
            r_first_seen <= 1'b0;
            r_first      <= '0;
            r_diff       <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_out.ready) begin
                        r_o_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_first      <= first_pix;
                        r_first_seen <= !i_in.frame_last;
                        r_diff       <= i_in.frame_last ? '0 : diff;
                        r_o_pixel    <= pix;
                        r_o_last     <= i_in.frame_last;
                        r_o_au       <= i_in.frame_last && au;
                        r_o_cu       <= i_in.frame_last && cu;
                        r_o_fa       <= i_in.frame_last ? fa : '0;
                        r_o_low      <= '0;
                        r_o_mid      <= '0;
                        r_o_high     <= '0;
                        if (i_in.frame_last && cu && fa != '0) begin
                            // hold the result until all three quotients are in
                            r_o_valid   <= 1'b0;
                            r_chan      <= '0;
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV;
                        end else begin
                            r_o_valid <= 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        case (r_chan)
                            2'd0:    r_o_low  <= div_rsp.quot;
                            2'd1:    r_o_mid  <= div_rsp.quot;
                            default: r_o_high <= div_rsp.quot;
                        endcase
                        if (r_chan == 2'(NUM_CHAN - 1)) begin
                            r_o_valid <= 1'b1;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_chan      <= r_chan + 1'b1;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.out_pixel        = r_o_pixel;
    assign o_out.is_last          = r_o_last;
    assign o_out.alpha_uniform    = r_o_au;
    assign o_out.color_uniform    = r_o_cu;
    assign o_out.first_alpha_byte = r_o_fa;
    assign o_out.unpremul_low     = r_o_low;
    assign o_out.unpremul_mid     = r_o_mid;
    assign o_out.unpremul_high    = r_o_high;

    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> r_state == ST_DIV)
        else $error("divider started outside division phase");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV && !r_div_start)
        else $error("divider finished when no division was pending");

    a_no_out_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !r_o_valid && !i_in.ready)
        else $error("result shown or item taken during division");

    a_cu_needs_au: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_cu |-> r_o_au && r_o_last)
        else $error("uniform color flagged without uniform alpha");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_last |-> r_o_fa == '0 && r_o_low == '0 && r_o_high == '0)
        else $error("analysis fields set on a pixel that is not last");

endmodule
